@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TDCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/tdcs_pkg.sv @@
package tdcs_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int KEY_W         = 24;
  localparam int TICK_W        = 32;
  localparam int CNT_W         = 5;
  localparam int QUANT_W       = 16;
  localparam int SLOT_W        = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CNT_W-1:0]   COUNT_RST   = 5'd1;
  localparam logic [QUANT_W-1:0] QUANTUM_RST = 16'd500;
  localparam logic [CNT_W-1:0]   DONE_MAX    = 5'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY  = 2'd0,
    REG_COUNT   = 2'd1,
    REG_QUANTUM = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_RR   = 2'd1,
    POL_SJF  = 2'd2,
    POL_PSJF = 2'd3
  } policy_e;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic tick_start;
    logic scan_rd;
    logic mod_step;
    logic select;
    logic run_rd;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic n_zero;
    logic mod_need;
  } status_t;

endpackage

@@ hdl/tdcs_in_if.sv @@
interface tdcs_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [tdcs_pkg::SLOT_W-1:0] slot;
  logic [tdcs_pkg::KEY_W-1:0]  ready_time;
  logic [tdcs_pkg::KEY_W-1:0]  exec_time;

  modport source (output valid, kind, slot, ready_time, exec_time, input ready);
  modport sink   (input valid, kind, slot, ready_time, exec_time, output ready);
endinterface

@@ hdl/tdcs_out_if.sv @@
interface tdcs_out_if;
  logic                       valid;
  logic                       ready;
  logic                       cpu_busy;
  logic [tdcs_pkg::SLOT_W-1:0] running_slot;
  logic                       finished_valid;
  logic [tdcs_pkg::SLOT_W-1:0] finished_slot;
  logic                       all_done;

  modport source (output valid, cpu_busy, running_slot, finished_valid, finished_slot,
                  all_done, input ready);
  modport sink   (input valid, cpu_busy, running_slot, finished_valid, finished_slot,
                  all_done, output ready);
endinterface

@@ hdl/tdcs_ctrl.sv @@
`include "assert_macros.svh"

module tdcs_ctrl #(
  parameter int NUM_SLOTS = tdcs_pkg::NUM_SLOTS_DEF,
  localparam int NW = $clog2(NUM_SLOTS) + 1,
  localparam int SW = $clog2(NUM_SLOTS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_kind_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic [NW-1:0]       n_i,
  input  tdcs_pkg::status_t   status_i,
  output tdcs_pkg::cmd_t      cmd_o,
  output logic [SW-1:0]       scan_addr_o
);
  import tdcs_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_RET  = 8'b0000_0010,
    ST_SCAN = 8'b0000_0100,
    ST_SEND = 8'b0000_1000,
    ST_MOD  = 8'b0001_0000,
    ST_SEL  = 8'b0010_0000,
    ST_RUN  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          accept, out_free;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign scan_addr_o = cnt_q[SW-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind_i == KIND_TICK) begin
            state_d = ST_RET;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_RET: begin
        cmd_o.tick_start = 1'b1;
        cnt_d            = '0;
        state_d          = status_i.n_zero ? ST_SEND : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_rd  = 1'b1;
        cmd_o.mod_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == n_i - 1'b1) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        cmd_o.mod_step = 1'b1;
        state_d        = ST_MOD;
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (!status_i.mod_need) begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd_o.select = 1'b1;
        state_d      = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.run_rd = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `TDCS_ASSERT_NEXT(a_tick_starts, clk_i, rst_ni, accept && in_kind_i == KIND_TICK,
    state_q == ST_RET, "tick beat did not start the retire step")
  `TDCS_ASSERT(a_scan_in_range, clk_i, rst_ni, state_q != ST_SCAN || cnt_q < n_i,
    "scan address beyond active slots")

endmodule

@@ hdl/tdcs_dpath.sv @@
`include "assert_macros.svh"

module tdcs_dpath #(
  parameter int NUM_SLOTS = tdcs_pkg::NUM_SLOTS_DEF,
  localparam int NW = $clog2(NUM_SLOTS) + 1,
  localparam int SW = $clog2(NUM_SLOTS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tdcs_pkg::cmd_t                    cmd_i,
  output tdcs_pkg::status_t                 status_o,
  output logic [NW-1:0]                     n_o,
  input  logic [SW-1:0]                     scan_addr_i,
  input  logic [tdcs_pkg::SLOT_W-1:0]       ld_slot_i,
  input  logic [tdcs_pkg::KEY_W-1:0]        ld_ready_i,
  input  logic [tdcs_pkg::KEY_W-1:0]        ld_exec_i,
  input  logic                              cfg_we_i,
  input  logic [tdcs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tdcs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                              cpu_busy_o,
  output logic [tdcs_pkg::SLOT_W-1:0]       running_slot_o,
  output logic                              finished_valid_o,
  output logic [tdcs_pkg::SLOT_W-1:0]       finished_slot_o,
  output logic                              all_done_o
);
  import tdcs_pkg::*;

  typedef enum logic [1:0] {
    TAG_NONE = 2'd0,
    TAG_RET  = 2'd1,
    TAG_SCAN = 2'd2,
    TAG_RUN  = 2'd3
  } tag_e;

  // slot stores, one read and one write port each
  logic [KEY_W-1:0] ready_mem [NUM_SLOTS];
  logic [KEY_W-1:0] rem_mem   [NUM_SLOTS];
  logic [KEY_W-1:0] rdy_rd_q, rem_rd_q;
  logic [SW-1:0]    rd_addr, rd_idx_q;
  tag_e             tag_q, tag_d;

  policy_e            policy_q;
  logic [CNT_W-1:0]   count_q;
  logic [QUANT_W-1:0] quantum_q;

  logic [NUM_SLOTS-1:0] arrived_q, elig_q;
  logic [TICK_W-1:0]    now_q, last_sw_q;
  logic                 rv_q;
  logic [SW-1:0]        runner_q;
  logic [CNT_W-1:0]     done_q;
  logic                 fin_v_q;
  logic [SLOT_W-1:0]    fin_slot_q;
  logic                 min_v_q;
  logic [SW-1:0]        min_idx_q;
  logic [KEY_W-1:0]     min_key_q;
  logic [NW-1:0]        s0_q;

  logic             busy_q, fin_o_q, done_o_q;
  logic [SLOT_W-1:0] run_o_q, fin_slot_o_q;

  logic             ld_hit;
  logic [SW-1:0]    ld_addr;
  logic             rem_we;
  logic [SW-1:0]    rem_waddr;
  logic [KEY_W-1:0] rem_wdata;
  logic [NW-1:0]    n;
  logic             retire_hit;
  logic             arr_hit, arr_new, el_new;
  logic [KEY_W-1:0] key;

  logic             first_v, cyc_v, next_v, rot, fresh;
  logic [SW-1:0]    first_idx, cyc_idx, next_idx;
  logic [QUANT_W-1:0] q_eff;

  assign n = (int'(count_q) < NUM_SLOTS) ? NW'(count_q) : NW'(NUM_SLOTS);
  assign n_o = n;
  assign status_o.n_zero   = (n == '0);
  assign status_o.mod_need = (n != '0) && (s0_q >= n);

  assign ld_hit  = cmd_i.load && (int'(ld_slot_i) < NUM_SLOTS);
  assign ld_addr = SW'(ld_slot_i);

  always_comb begin
    rd_addr = runner_q;
    tag_d   = TAG_NONE;
    if (cmd_i.tick_start) begin
      tag_d = TAG_RET;
    end else if (cmd_i.scan_rd) begin
      rd_addr = scan_addr_i;
      tag_d   = TAG_SCAN;
    end else if (cmd_i.run_rd && rv_q) begin
      tag_d = TAG_RUN;
    end
  end

  // remaining-time write: load or decrement of the runner
  always_comb begin
    rem_we    = 1'b0;
    rem_waddr = runner_q;
    rem_wdata = rem_rd_q - 1'b1;
    if (ld_hit) begin
      rem_we    = 1'b1;
      rem_waddr = ld_addr;
      rem_wdata = ld_exec_i;
    end else if (tag_q == TAG_RUN && rem_rd_q != '0) begin
      rem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_hit) begin
      ready_mem[ld_addr] <= ld_ready_i;
    end
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    rdy_rd_q <= ready_mem[rd_addr];
    rem_rd_q <= rem_mem[rd_addr];
    rd_idx_q <= rd_addr;
  end

  assign retire_hit = (tag_q == TAG_RET) && rv_q && (rem_rd_q == '0);
  assign arr_hit    = !arrived_q[rd_idx_q] && ({{(TICK_W-KEY_W){1'b0}}, rdy_rd_q} == now_q);
  assign arr_new    = arrived_q[rd_idx_q] || arr_hit;
  assign el_new     = arr_new && (rem_rd_q != '0);
  assign key        = (policy_q == POL_FIFO) ? rdy_rd_q : rem_rd_q;

  // selection
  always_comb begin
    first_v   = 1'b0;
    first_idx = '0;
    cyc_v     = 1'b0;
    cyc_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (elig_q[i]) begin
        first_v   = 1'b1;
        first_idx = SW'(i);
      end
      if (elig_q[i] && (NW'(i) >= s0_q)) begin
        cyc_v   = 1'b1;
        cyc_idx = SW'(i);
      end
    end
    if (!cyc_v) begin
      cyc_v   = first_v;
      cyc_idx = first_idx;
    end
    q_eff = (quantum_q == '0) ? QUANT_W'(1) : quantum_q;
    rot   = rv_q && ((now_q - last_sw_q) >= {{(TICK_W-QUANT_W){1'b0}}, q_eff});
    next_v   = min_v_q;
    next_idx = min_idx_q;
    case (policy_q)
      POL_RR: begin
        if (!rv_q) begin
          next_v   = first_v;
          next_idx = first_idx;
        end else if (!rot) begin
          next_v   = 1'b1;
          next_idx = runner_q;
        end else begin
          next_v   = cyc_v;
          next_idx = cyc_idx;
        end
      end
      POL_SJF: begin
        if (rv_q) begin
          next_v   = 1'b1;
          next_idx = runner_q;
        end
      end
      default: begin
        next_v   = min_v_q;
        next_idx = min_idx_q;
      end
    endcase
    fresh = !rv_q || (runner_q != next_idx) || ((policy_q == POL_RR) && rot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= POL_FIFO;
      count_q   <= COUNT_RST;
      quantum_q <= QUANTUM_RST;
      tag_q     <= TAG_NONE;
      arrived_q <= '0;
      elig_q    <= '0;
      now_q     <= '0;
      last_sw_q <= '0;
      rv_q      <= 1'b0;
      runner_q  <= '0;
      done_q    <= '0;
      fin_v_q   <= 1'b0;
      min_v_q   <= 1'b0;
      s0_q      <= '0;
      busy_q    <= 1'b0;
      fin_o_q   <= 1'b0;
      done_o_q  <= 1'b0;
    end else begin
      tag_q <= tag_d;
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_POLICY:  policy_q  <= policy_e'(cfg_data_i[1:0]);
          REG_COUNT:   count_q   <= cfg_data_i[CNT_W-1:0];
          REG_QUANTUM: quantum_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ld_hit) begin
        arrived_q[ld_addr] <= 1'b0;
        if (rv_q && runner_q == ld_addr) begin
          rv_q <= 1'b0;
        end
      end
      if (cmd_i.tick_start) begin
        fin_v_q <= 1'b0;
        min_v_q <= 1'b0;
        elig_q  <= '0;
        s0_q    <= NW'(runner_q) + 1'b1;
      end
      if (cmd_i.mod_step && status_o.mod_need) begin
        s0_q <= s0_q - n;
      end
      if (retire_hit) begin
        rv_q    <= 1'b0;
        fin_v_q <= 1'b1;
        if (done_q != DONE_MAX) begin
          done_q <= done_q + 1'b1;
        end
      end
      if (tag_q == TAG_SCAN) begin
        arrived_q[rd_idx_q] <= arr_new;
        elig_q[rd_idx_q]    <= el_new;
        if (el_new && (!min_v_q || key < min_key_q)) begin
          min_v_q <= 1'b1;
        end
      end
      if (cmd_i.select && next_v) begin
        rv_q     <= 1'b1;
        runner_q <= next_idx;
        if (fresh) begin
          last_sw_q <= now_q;
        end
      end
      if (cmd_i.out_load) begin
        busy_q   <= rv_q;
        fin_o_q  <= fin_v_q;
        done_o_q <= (done_q >= count_q);
        now_q    <= now_q + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_start) begin
      fin_slot_q <= SLOT_W'(runner_q);
    end
    if (tag_q == TAG_SCAN && el_new && (!min_v_q || key < min_key_q)) begin
      min_idx_q <= rd_idx_q;
      min_key_q <= key;
    end
    if (cmd_i.out_load) begin
      run_o_q      <= rv_q ? SLOT_W'(runner_q) : '0;
      fin_slot_o_q <= fin_v_q ? fin_slot_q : '0;
    end
  end

  assign cpu_busy_o       = busy_q;
  assign running_slot_o   = run_o_q;
  assign finished_valid_o = fin_o_q;
  assign finished_slot_o  = fin_slot_o_q;
  assign all_done_o       = done_o_q;

  `TDCS_ASSERT(a_done_mono, clk_i, rst_ni, done_q >= $past(done_q),
    "completion count went backwards")
  `TDCS_ASSERT_NEXT(a_retire_clears, clk_i, rst_ni, retire_hit, !rv_q,
    "retired runner still marked valid")

endmodule

@@ hdl/tick_driven_cpu_scheduler_top.sv @@
// Tick-driven CPU scheduler, up to NUM_SLOTS process slots.
// Input channel in_i: a beat with kind=0 loads a slot (ready time, run length);
// kind=1 advances time by one unit and yields exactly one result beat.
// Output channel out_o: per tick, running slot, finished slot and completion.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i write policy, process count,
// quantum; write only while the block is idle.
// Sequencing: a load is written to the slot stores as it is accepted. A tick
// steps through retire, a scan of the n = min(process_count, NUM_SLOTS)
// active slots (skipped when n is zero), start-slot reduction, select, run
// read and output; the scan goes through the single read port of the slot
// stores, and a runner beyond the active slots after a count change adds
// reduction steps for the round-robin start slot.
// One tick is in flight at a time; the next beat is taken as soon as the
// result is registered, even while out_o is stalled.
// If the receiver stalls, the result holds in the output register and a later
// tick waits in its final step until the register frees.
// Reset clears time, runner, arrival flags, completion count and config
// (FIFO, count 1, quantum 500). Slot contents are undefined until loaded.
module tick_driven_cpu_scheduler_top #(
  parameter int NUM_SLOTS = tdcs_pkg::NUM_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tdcs_in_if.sink                         in_i,
  tdcs_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [tdcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tdcs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tdcs_pkg::*;

  localparam int NW = $clog2(NUM_SLOTS) + 1;
  localparam int SW = $clog2(NUM_SLOTS);

  cmd_t          cmd;
  status_t       status;
  logic [NW-1:0] n;
  logic [SW-1:0] scan_addr;

  // sequencer: load, retire, scan, start-slot reduction, select, run, deliver
  tdcs_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .n_i         (n),
    .status_i    (status),
    .cmd_o       (cmd),
    .scan_addr_o (scan_addr)
  );

  // slot stores, scheduler state, config and result register
  tdcs_dpath #(.NUM_SLOTS(NUM_SLOTS)) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .n_o              (n),
    .scan_addr_i      (scan_addr),
    .ld_slot_i        (in_i.slot),
    .ld_ready_i       (in_i.ready_time),
    .ld_exec_i        (in_i.exec_time),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .cpu_busy_o       (out_o.cpu_busy),
    .running_slot_o   (out_o.running_slot),
    .finished_valid_o (out_o.finished_valid),
    .finished_slot_o  (out_o.finished_slot),
    .all_done_o       (out_o.all_done)
  );

endmodule
